// ===== src/crs_pkg.sv =====
// crs_pkg: shared widths, status codes and helpers for the chebyshev root step unit
// no dependencies
package crs_pkg;

  localparam int unsigned XW   = 48;  // q16.32 value width
  localparam int unsigned MW   = 47;  // magnitude limit width
  localparam int unsigned NUMW = 95;  // divider numerator / quotient width
  localparam int unsigned PRW  = 95;  // multiplier product width
  localparam int unsigned ITW  = 10;  // iteration counter width

  typedef enum logic [2:0] {
    ST_CONTINUE  = 3'd0,
    ST_CONVERGED = 3'd1,
    ST_DERIV_LOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVERGING = 3'd4,
    ST_STALLED   = 3'd5,
    ST_LIMIT     = 3'd6,
    ST_IDLE      = 3'd7
  } status_e;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic [1:0] REG_INIT_GUESS = 2'd0;
  localparam logic [1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [1:0] REG_MAX_ITER   = 2'd2;
  localparam logic [1:0] REG_DERIV_FLR  = 2'd3;

  // handshake between sequencer and a serial arithmetic unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  function automatic logic [XW-1:0] mag48(input logic [XW-1:0] v);
    mag48 = v[XW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== src/crs_if.sv =====
// crs_in_if / crs_out_if: valid-ready request channels of the root step unit
// depends on crs_pkg
interface crs_in_if import crs_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          cmd;
  logic [XW-1:0] f_value;
  logic [XW-1:0] d1_value;
  logic [XW-1:0] d2_value;
  modport source (output valid, cmd, f_value, d1_value, d2_value, input ready);
  modport sink   (input valid, cmd, f_value, d1_value, d2_value, output ready);
endinterface

interface crs_out_if import crs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [XW-1:0]  point;
  logic [2:0]     status;
  logic [ITW-1:0] iteration;
  modport source (output valid, point, status, iteration, input ready);
  modport sink   (input valid, point, status, iteration, output ready);
endinterface

// ===== src/crs_divider.sv =====
// crs_divider: restoring divider, one quotient bit per cycle
// depends on crs_pkg
module crs_divider import crs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  unit_ctl_t       ctl_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [XW-1:0]   den_i,
  output logic            done_o,
  output logic [NUMW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NUMW + 1);

  logic [NUMW-1:0] sh_q, sh_d;
  logic [XW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [XW:0]     trial, diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, sh_q[NUMW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = trial >= {1'b0, den_i};
    sh_d = sh_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (ctl_i.start) begin
      sh_d = num_i; rem_d = '0; cnt_d = CW'(NUMW); busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[NUMW-2:0], ge};
      rem_d = ge ? diff[XW-1:0] : trial[XW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sh_q <= '0; rem_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sh_q <= sh_d; rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
endmodule

// ===== src/crs_multiplier.sv =====
// crs_multiplier: shift-add multiplier, one multiplier bit per cycle
// depends on crs_pkg
module crs_multiplier import crs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  unit_ctl_t      ctl_i,
  input  logic [MW-1:0]  a_i,
  input  logic [XW-1:0]  b_i,
  output logic           done_o,
  output logic [PRW-1:0] prod_o
);
  localparam int unsigned CW = $clog2(MW + 1);

  logic [XW-1:0] hi_q, hi_d;
  logic [MW-1:0] lo_q, lo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [XW:0]   sum;

  always_comb begin
    sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_i} : '0);
    hi_d = hi_q; lo_d = lo_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (ctl_i.start) begin
      hi_d = '0; lo_d = a_i; cnt_d = CW'(MW); busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = sum[XW:1];
      lo_d  = {sum[0], lo_q[MW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; hi_q <= '0; lo_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; hi_q <= hi_d; lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};
endmodule

// ===== src/chebyshev_root_step_unit.sv =====
// chebyshev_root_step_unit: one chebyshev iteration step in signed q16.32
// sequencing: start and idle requests go straight to the output register; an evaluate
//   request runs two serial divisions and two serial multiplies in turn, then sums
//   and checks the new point before it is handed over
// throughput: one request at a time; a new request is taken once the result is
//   handed to the output register, which may still wait for the sink
// reset: asynchronous active low, engine idle, point and counters zero, registers at defaults
module chebyshev_root_step_unit import crs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  crs_in_if.sink      in_if,
  crs_out_if.source   out_if
);
  typedef enum logic [3:0] {
    S_IDLE, S_MAG, S_CHECK, S_DIV1, S_MUL1, S_DIV2, S_MUL2,
    S_SUM, S_XNEW, S_FINAL, S_EMIT
  } state_e;

  // configuration registers
  logic [XW-1:0]  init_guess_q;
  logic [MW-1:0]  tol_q, dfloor_q;
  logic [ITW-1:0] max_iter_q;

  // iteration state
  logic [XW-1:0]  cur_x_q, prev_x_q;
  logic [ITW-1:0] iter_q;
  logic           running_q;

  // per-request working registers
  state_e         state_q;
  logic [XW-1:0]  f_q, d1_q, d2_q;
  logic [XW-1:0]  af_q, ad_q, ad2_q;
  logic           sc_q, sq_q;
  logic [MW-1:0]  c_q, qm_q, h_q;
  logic [XW:0]    pc_q;        // |x - previous x|
  logic [55:0]    pc100_q;     // 100 * |x - previous x|
  logic [XW:0]    ch_q;        // signed c + h
  logic [XW+1:0]  xn_q;        // candidate next point, wide for range check
  logic [XW-1:0]  chg_q;       // |x_new - x|

  // pending result and output register
  logic [XW-1:0]  res_point_q;
  status_e        res_status_q;
  logic [ITW-1:0] res_iter_q;
  logic           ov_q;
  logic [XW-1:0]  o_point_q;
  logic [2:0]     o_status_q;
  logic [ITW-1:0] o_iter_q;

  // serial arithmetic units
  unit_ctl_t       div_ctl, mul_ctl;
  logic [NUMW-1:0] div_num, div_quo;
  logic [MW-1:0]   mul_a;
  logic [XW-1:0]   mul_b;
  logic            div_done, mul_done;
  logic [PRW-1:0]  mul_prod;

  crs_divider u_div (
    .clk_i, .rst_ni, .ctl_i(div_ctl), .num_i(div_num), .den_i(ad_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  crs_multiplier u_mul (
    .clk_i, .rst_ni, .ctl_i(mul_ctl), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  // divider operand: f scaled by 2^32 first, then c * |f''|
  assign div_num = (state_q == S_CHECK) ? {15'd0, af_q, 32'd0} : mul_prod;
  // multiplier operands: c * |f''| first, then c * q
  // a is loaded at start, c comes straight from the divider on the first pass
  assign mul_a   = (state_q == S_DIV1) ? div_quo[MW-1:0] : c_q;
  // b is read every cycle while the multiplier runs
  assign mul_b   = (state_q == S_MUL2) ? {1'b0, qm_q} : ad2_q;

  logic chk_conv, chk_dlow, quo_ovf, h_ovf, xn_oor;
  logic [XW:0] diffx;
  logic [XW:0] cs, hs;
  logic [ITW-1:0] iter_inc;

  always_comb begin
    chk_conv = {1'b0, tol_q} > af_q;
    chk_dlow = {1'b0, dfloor_q} > ad_q;
    quo_ovf  = div_quo[NUMW-1:MW] != '0;
    h_ovf    = mul_prod[PRW-1:80] != '0;
    diffx    = {cur_x_q[XW-1], cur_x_q} - {prev_x_q[XW-1], prev_x_q};
    cs       = sc_q ? -{2'b00, c_q} : {2'b00, c_q};
    hs       = (sc_q ^ sq_q) ? -{2'b00, h_q} : {2'b00, h_q};
    xn_oor   = !(xn_q[XW+1:XW-1] == 3'b000 || xn_q[XW+1:XW-1] == 3'b111);
    iter_inc = iter_q + 1'b1;
    div_ctl.start = 1'b0;
    mul_ctl.start = 1'b0;
    case (state_q)
      S_CHECK: div_ctl.start = !chk_conv && !chk_dlow && (ad_q != '0);
      S_DIV1:  mul_ctl.start = div_done && !quo_ovf;
      S_MUL1:  div_ctl.start = mul_done;
      S_DIV2:  mul_ctl.start = div_done && !quo_ovf;
      default: ;
    endcase
  end

  assign in_if.ready      = (state_q == S_IDLE);
  assign out_if.valid     = ov_q;
  assign out_if.point     = o_point_q;
  assign out_if.status    = o_status_q;
  assign out_if.iteration = o_iter_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_guess_q <= '0;
      tol_q        <= MW'(4295);
      max_iter_q   <= ITW'(100);
      dfloor_q     <= MW'(43);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INIT_GUESS: init_guess_q <= cfg_data_i;
        REG_TOLERANCE:  tol_q        <= cfg_data_i[MW-1:0];
        REG_MAX_ITER:   max_iter_q   <= cfg_data_i[ITW-1:0];
        REG_DERIV_FLR:  dfloor_q     <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_x_q <= '0; prev_x_q <= '0; iter_q <= '0; running_q <= 1'b0;
      f_q <= '0; d1_q <= '0; d2_q <= '0; af_q <= '0; ad_q <= '0; ad2_q <= '0;
      sc_q <= 1'b0; sq_q <= 1'b0; c_q <= '0; qm_q <= '0; h_q <= '0;
      pc_q <= '0; pc100_q <= '0; ch_q <= '0; xn_q <= '0; chg_q <= '0;
      res_point_q <= '0; res_status_q <= ST_CONTINUE; res_iter_q <= '0;
      ov_q <= 1'b0; o_point_q <= '0; o_status_q <= '0; o_iter_q <= '0;
    end else begin
      // output register drains; a handover in S_EMIT refills it in the same cycle
      if (ov_q && out_if.ready && state_q != S_EMIT) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            f_q <= in_if.f_value; d1_q <= in_if.d1_value; d2_q <= in_if.d2_value;
            if (in_if.cmd == CMD_START) begin
              // restart from the configured guess
              cur_x_q   <= init_guess_q;
              prev_x_q  <= init_guess_q;
              iter_q    <= '0;
              running_q <= (max_iter_q != '0);
              res_point_q  <= init_guess_q;
              res_status_q <= (max_iter_q == '0) ? ST_LIMIT : ST_CONTINUE;
              res_iter_q   <= '0;
              state_q <= S_EMIT;
            end else if (!running_q) begin
              res_point_q <= cur_x_q; res_status_q <= ST_IDLE; res_iter_q <= iter_q;
              state_q <= S_EMIT;
            end else begin
              state_q <= S_MAG;
            end
          end
        end
        S_MAG: begin
          af_q  <= mag48(f_q);
          ad_q  <= mag48(d1_q);
          ad2_q <= mag48(d2_q);
          sc_q  <= f_q[XW-1] ^ d1_q[XW-1];
          pc_q  <= diffx[XW] ? -diffx : diffx;
          res_point_q <= cur_x_q;
          res_iter_q  <= iter_q;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          // early exits in priority order: converged, derivative small, zero derivative
          pc100_q <= ({7'd0, pc_q} << 6) + ({7'd0, pc_q} << 5) + ({7'd0, pc_q} << 2);
          if (chk_conv) begin
            res_status_q <= ST_CONVERGED; running_q <= 1'b0; state_q <= S_EMIT;
          end else if (chk_dlow) begin
            res_status_q <= ST_DERIV_LOW; running_q <= 1'b0; state_q <= S_EMIT;
          end else if (ad_q == '0) begin
            res_status_q <= ST_OVERFLOW; running_q <= 1'b0; state_q <= S_EMIT;
          end else begin
            state_q <= S_DIV1;
          end
        end
        S_DIV1: begin
          // c = f * 2^32 / f'
          if (div_done) begin
            if (quo_ovf) begin
              res_status_q <= ST_OVERFLOW; running_q <= 1'b0; state_q <= S_EMIT;
            end else begin
              c_q <= div_quo[MW-1:0];
              state_q <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          if (mul_done) state_q <= S_DIV2;
        end
        S_DIV2: begin
          // q = c * f'' / f'
          if (div_done) begin
            if (quo_ovf) begin
              res_status_q <= ST_OVERFLOW; running_q <= 1'b0; state_q <= S_EMIT;
            end else begin
              qm_q <= div_quo[MW-1:0];
              sq_q <= sc_q ^ d2_q[XW-1] ^ d1_q[XW-1];
              state_q <= S_MUL2;
            end
          end
        end
        S_MUL2: begin
          // h = c * q / 2^33
          if (mul_done) begin
            if (h_ovf) begin
              res_status_q <= ST_OVERFLOW; running_q <= 1'b0; state_q <= S_EMIT;
            end else begin
              h_q <= mul_prod[79:33];
              state_q <= S_SUM;
            end
          end
        end
        S_SUM: begin
          ch_q <= cs + hs;
          state_q <= S_XNEW;
        end
        S_XNEW: begin
          xn_q  <= {{2{cur_x_q[XW-1]}}, cur_x_q} - {ch_q[XW], ch_q};
          chg_q <= ch_q[XW] ? XW'(-ch_q) : ch_q[XW-1:0];
          state_q <= S_FINAL;
        end
        S_FINAL: begin
          state_q <= S_EMIT;
          if (xn_oor) begin
            res_status_q <= ST_OVERFLOW; running_q <= 1'b0;
          end else if (iter_q > ITW'(3) && {8'd0, chg_q} > pc100_q) begin
            res_status_q <= ST_DIVERGING; running_q <= 1'b0;
          end else if (iter_q != '0 && chg_q == '0 && af_q > {1'b0, tol_q}) begin
            res_status_q <= ST_STALLED; running_q <= 1'b0;
          end else begin
            // accept the step
            prev_x_q    <= cur_x_q;
            cur_x_q     <= xn_q[XW-1:0];
            iter_q      <= iter_inc;
            res_point_q <= xn_q[XW-1:0];
            res_iter_q  <= iter_inc;
            if (iter_inc >= max_iter_q) begin
              res_status_q <= ST_LIMIT; running_q <= 1'b0;
            end else begin
              res_status_q <= ST_CONTINUE;
            end
          end
        end
        S_EMIT: begin
          // hand over once the output register is free
          if (!ov_q || out_if.ready) begin
            ov_q       <= 1'b1;
            o_point_q  <= res_point_q;
            o_status_q <= res_status_q;
            o_iter_q   <= res_iter_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
